>>> src/rra_pkg.sv
// ----------------------------------------------------------------------------
// rra_pkg: shared types and constants of the ring region allocator
// Field widths, alignment masks, the state and result records and the
// helper that rounds the configured region size.
// ----------------------------------------------------------------------------
package rra_pkg;

  localparam int unsigned SIZE_W    = 19;
  localparam int unsigned HEAD_W    = 18;
  localparam int unsigned LEN_W     = 16;
  localparam int unsigned NEED_W    = 17;
  localparam int unsigned CNT_W     = 32;
  localparam int unsigned BYTES_W   = 48;
  localparam int unsigned MOD_STEPS = SIZE_W;
  localparam int unsigned MOD_CNT_W = 5;

  localparam logic [SIZE_W-1:0] MAX_REGION_BYTES = 19'd262144;
  localparam logic [SIZE_W-1:0] USED_MAX         = '1;
  localparam logic [2:0]        ALIGN8_MASK      = 3'd7;
  localparam logic [5:0]        ALIGN64_MASK     = 6'd63;

  typedef enum logic {
    MODE_ALLOC   = 1'b0,
    MODE_RELEASE = 1'b1
  } mode_e;

  typedef struct packed {
    logic [HEAD_W-1:0]  head;
    logic [SIZE_W-1:0]  used;
    logic [CNT_W-1:0]   grants;
    logic [BYTES_W-1:0] byte_total;
    logic [CNT_W-1:0]   refusals;
  } rra_state_t;

  typedef struct packed {
    logic              ok;
    logic [HEAD_W-1:0] offset;
    logic [SIZE_W-1:0] charged;
  } rra_result_t;

  // Rounds the raw size up to a multiple of 64 and caps it at the maximum.
  function automatic logic [SIZE_W-1:0] effective_size(input logic [SIZE_W-1:0] raw);
    logic [SIZE_W:0] sum;
    sum = {1'b0, raw} + (SIZE_W+1)'(ALIGN64_MASK);
    sum[5:0] = '0;
    if (sum > {1'b0, MAX_REGION_BYTES}) begin
      return MAX_REGION_BYTES;
    end
    return sum[SIZE_W-1:0];
  endfunction

endpackage

>>> src/ring_region_allocator.sv
// ----------------------------------------------------------------------------
// ring_region_allocator: contiguous slice allocator over a circular region
// Grants 8-byte-aligned slices in FIFO order and takes them back on release.
// ----------------------------------------------------------------------------
// Usage:
// The input channel (in_valid_i / in_stall_o) carries one transaction per
// allocate or release; the output channel (out_valid_o / out_stall_i)
// returns exactly one result per transaction, in order, with the counter
// values as they stand after that transaction.
// Each transaction is captured in an input register, decided by one pass of
// logic and written to the result register. One transaction per cycle is
// sustained while the receiver takes results and no remainder is in
// progress. When the receiver stalls, the result register holds and one more
// transaction may wait in the input register before in_stall_o rises.
// If the region was shrunk while the head lay beyond its new end, the next
// grant that needs the head wrapped modulo the size runs the remainder unit,
// and no further transaction is decided until it finishes.
// The region size register is written on the cfg channel while idle, by the
// user; only a remainder blocks cfg. A size of zero refuses every allocation.
// Reset clears size, head, used count and counters; no clearing pass needed.
// ----------------------------------------------------------------------------
module ring_region_allocator (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        cfg_valid_i,
  output logic                        cfg_ready_o,
  input  logic [rra_pkg::SIZE_W-1:0]  region_size_i,
  input  logic                        in_valid_i,
  output logic                        in_stall_o,
  input  logic                        mode_i,
  input  logic [rra_pkg::LEN_W-1:0]   length_i,
  input  logic [rra_pkg::SIZE_W-1:0]  release_bytes_i,
  output logic                        out_valid_o,
  input  logic                        out_stall_i,
  output logic                        ok_o,
  output logic [rra_pkg::HEAD_W-1:0]  offset_o,
  output logic [rra_pkg::SIZE_W-1:0]  charged_bytes_o,
  output logic [rra_pkg::CNT_W-1:0]   packets_sent_o,
  output logic [rra_pkg::BYTES_W-1:0] bytes_sent_o,
  output logic [rra_pkg::CNT_W-1:0]   refusals_o
);
  import rra_pkg::*;

  logic              size_wr;
  logic [SIZE_W-1:0] size_q;

  logic              s1_valid_q, s1_valid_d;
  logic              s1_mode_q;
  logic [LEN_W-1:0]  s1_length_q;
  logic [SIZE_W-1:0] s1_rel_q;

  logic              out_valid_q, out_valid_d;
  rra_result_t       res_q;
  rra_state_t        snap_q;

  rra_state_t        state_q, state_d;
  rra_result_t       core_res;
  logic              mod_start;
  logic [SIZE_W-1:0] mod_num;
  logic              mod_busy;
  logic              mod_done;
  logic [HEAD_W-1:0] mod_rem;

  logic              accept;
  logic              advance;

  rra_core u_core (
    .state_i         (state_q),
    .size_i          (size_q),
    .mode_i          (s1_mode_q),
    .length_i        (s1_length_q),
    .release_bytes_i (s1_rel_q),
    .state_o         (state_d),
    .result_o        (core_res),
    .mod_start_o     (mod_start),
    .mod_num_o       (mod_num)
  );

  rra_mod u_mod (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (advance & mod_start),
    .num_i   (mod_num),
    .den_i   (size_q),
    .busy_o  (mod_busy),
    .done_o  (mod_done),
    .rem_o   (mod_rem)
  );

  assign cfg_ready_o = !mod_busy;
  assign size_wr     = cfg_valid_i && cfg_ready_o;

  // The head is not valid while a remainder is in progress.
  assign advance     = s1_valid_q && !mod_busy && (!out_valid_q || !out_stall_i);
  assign in_stall_o  = s1_valid_q && !advance;
  assign accept      = in_valid_i && !in_stall_o;
  assign s1_valid_d  = accept || (s1_valid_q && !advance);
  assign out_valid_d = advance || (out_valid_q && out_stall_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      size_q      <= '0;
      state_q     <= '0;
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      s1_valid_q  <= s1_valid_d;
      out_valid_q <= out_valid_d;
      if (size_wr) begin
        size_q <= effective_size(region_size_i);
      end
      if (advance) begin
        state_q <= state_d;
      end else if (mod_done) begin
        state_q.head <= mod_rem;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      s1_mode_q   <= mode_i;
      s1_length_q <= length_i;
      s1_rel_q    <= release_bytes_i;
    end
    if (advance) begin
      res_q  <= core_res;
      snap_q <= state_d;
    end
  end

  assign out_valid_o     = out_valid_q;
  assign ok_o            = res_q.ok;
  assign offset_o        = res_q.offset;
  assign charged_bytes_o = res_q.charged;
  assign packets_sent_o  = snap_q.grants;
  assign bytes_sent_o    = snap_q.byte_total;
  assign refusals_o      = snap_q.refusals;

endmodule

>>> src/rra_mod.sv
// ----------------------------------------------------------------------------
// rra_mod: iterative remainder unit
// Restoring remainder of a 19-bit value by the region size, one quotient
// bit per cycle. Used only when the head lies beyond a shrunken region.
// ----------------------------------------------------------------------------
module rra_mod (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       start_i,
  input  logic [rra_pkg::SIZE_W-1:0] num_i,
  input  logic [rra_pkg::SIZE_W-1:0] den_i,
  output logic                       busy_o,
  output logic                       done_o,
  output logic [rra_pkg::HEAD_W-1:0] rem_o
);
  import rra_pkg::*;

  logic                 running_q, running_d;
  logic [MOD_CNT_W-1:0] cnt_q, cnt_d;
  logic [SIZE_W-1:0]    num_q, den_q, rem_q;
  logic [SIZE_W:0]      rem_sh;
  logic [SIZE_W:0]      rem_next;

  always_comb begin
    rem_sh = {rem_q, num_q[SIZE_W-1]};
    if (rem_sh >= {1'b0, den_q}) begin
      rem_next = rem_sh - {1'b0, den_q};
    end else begin
      rem_next = rem_sh;
    end
    done_o    = running_q && (cnt_q == MOD_CNT_W'(MOD_STEPS - 1));
    running_d = running_q;
    cnt_d     = cnt_q;
    if (start_i) begin
      running_d = 1'b1;
      cnt_d     = '0;
    end else if (running_q) begin
      cnt_d = cnt_q + 1'b1;
      if (done_o) begin
        running_d = 1'b0;
      end
    end
  end

  assign busy_o = running_q;
  // The remainder is below the divisor, at most 2^18, so it fits HEAD_W.
  assign rem_o  = rem_next[HEAD_W-1:0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      running_q <= 1'b0;
      cnt_q     <= '0;
    end else begin
      running_q <= running_d;
      cnt_q     <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      num_q <= num_i;
      den_q <= den_i;
      rem_q <= '0;
    end else if (running_q) begin
      num_q <= {num_q[SIZE_W-2:0], 1'b0};
      rem_q <= rem_next[SIZE_W-1:0];
    end
  end

endmodule

>>> src/rra_core.sv
// ----------------------------------------------------------------------------
// rra_core: allocation decision logic
// Given the current state and one transaction, decides grant or refusal,
// computes the slice offset, charge, next head, used count and counters.
// ----------------------------------------------------------------------------
module rra_core (
  input  rra_pkg::rra_state_t         state_i,
  input  logic [rra_pkg::SIZE_W-1:0]  size_i,
  input  logic                        mode_i,
  input  logic [rra_pkg::LEN_W-1:0]   length_i,
  input  logic [rra_pkg::SIZE_W-1:0]  release_bytes_i,
  output rra_pkg::rra_state_t         state_o,
  output rra_pkg::rra_result_t        result_o,
  output logic                        mod_start_o,
  output logic [rra_pkg::SIZE_W-1:0]  mod_num_o
);
  import rra_pkg::*;

  logic [NEED_W-1:0] need;
  logic [SIZE_W-1:0] need_w;
  logic [SIZE_W-1:0] head_w;
  logic [SIZE_W-1:0] room_end;
  logic [SIZE_W-1:0] gap;
  logic [SIZE_W-1:0] free_total;
  logic              grant;
  logic              wrap;
  logic [SIZE_W-1:0] skip;
  logic [SIZE_W-1:0] base;
  logic [SIZE_W-1:0] next_x;
  logic [SIZE_W-1:0] next_sub;
  logic [SIZE_W:0]   charged_sum;
  logic [SIZE_W+1:0] used_sum;

  always_comb begin
    need       = (NEED_W'(length_i) + NEED_W'(ALIGN8_MASK)) & ~NEED_W'(ALIGN8_MASK);
    need_w     = SIZE_W'(need);
    head_w     = {1'b0, state_i.head};
    room_end   = (head_w < size_i) ? size_i - head_w : '0;
    gap        = head_w - state_i.used;
    free_total = size_i - state_i.used;

    grant = 1'b1;
    wrap  = 1'b0;
    if (state_i.used >= size_i) begin
      grant = 1'b0;
    end else if (head_w >= state_i.used) begin
      // Tail too short: wrap to the start if the space before head suffices.
      if (room_end < need_w) begin
        if (gap >= need_w) begin
          wrap = 1'b1;
        end else begin
          grant = 1'b0;
        end
      end
    end else if (free_total < need_w) begin
      grant = 1'b0;
    end

    skip        = wrap ? room_end : '0;
    base        = wrap ? '0 : head_w;
    next_x      = base + need_w;
    next_sub    = next_x - size_i;
    charged_sum = {1'b0, skip} + {1'b0, need_w};
    used_sum    = {2'b00, state_i.used} + {2'b00, skip} + {2'b00, need_w};

    state_o     = state_i;
    result_o    = '0;
    mod_start_o = 1'b0;
    mod_num_o   = next_x;

    if (mode_e'(mode_i) == MODE_RELEASE) begin
      state_o.used = (state_i.used > release_bytes_i) ?
                     state_i.used - release_bytes_i : '0;
      result_o.ok  = 1'b1;
    end else if (grant) begin
      result_o.ok      = 1'b1;
      result_o.offset  = base[HEAD_W-1:0];
      result_o.charged = charged_sum[SIZE_W-1:0];
      // The new head is below twice the size unless the head had been left
      // beyond a shrunken region; that case goes to the remainder unit.
      if (next_x < size_i) begin
        state_o.head = next_x[HEAD_W-1:0];
      end else if (next_sub < size_i) begin
        state_o.head = next_sub[HEAD_W-1:0];
      end else begin
        mod_start_o = 1'b1;
      end
      state_o.used       = (used_sum > (SIZE_W+2)'(USED_MAX)) ?
                           USED_MAX : used_sum[SIZE_W-1:0];
      state_o.grants     = state_i.grants + 1'b1;
      state_o.byte_total = state_i.byte_total + BYTES_W'(length_i);
    end else begin
      state_o.refusals = state_i.refusals + 1'b1;
    end
  end

endmodule

>>> src/rra_checker.sv
// ----------------------------------------------------------------------------
// rra_checker: port-level checks of the ring region allocator
// Watches the result channel for hold behavior and slice consistency.
// ----------------------------------------------------------------------------
module rra_checker (
  input logic                        clk_i,
  input logic                        rst_ni,
  input logic                        out_valid_o,
  input logic                        out_stall_i,
  input logic                        ok_o,
  input logic [rra_pkg::HEAD_W-1:0]  offset_o,
  input logic [rra_pkg::SIZE_W-1:0]  charged_bytes_o,
  input logic [rra_pkg::CNT_W-1:0]   packets_sent_o,
  input logic [rra_pkg::BYTES_W-1:0] bytes_sent_o,
  input logic [rra_pkg::CNT_W-1:0]   refusals_o
);

  // A stalled result stays offered.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o)
    else $error("result dropped while stalled");

  // A stalled result keeps every field unchanged.
  a_out_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=>
      $stable({ok_o, offset_o, charged_bytes_o, packets_sent_o, bytes_sent_o, refusals_o}))
    else $error("result changed while stalled");

  // A refused slice carries no placement and no charge; a release reports ok.
  a_refuse_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !ok_o |-> (offset_o == '0) && (charged_bytes_o == '0))
    else $error("refusal with nonzero offset or charge");

  // Slices and charges stay 8-byte aligned, wrap space included.
  a_aligned: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (offset_o[2:0] == 3'd0) && (charged_bytes_o[2:0] == 3'd0))
    else $error("misaligned slice offset or charge");

endmodule

bind ring_region_allocator rra_checker u_rra_checker (.*);
